FILE: rtl/encoder_and_button_counter_core_macros.svh
// Assertion macros used by the port-level checker file.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ENCODER_AND_BUTTON_COUNTER_CORE_MACROS_SVH
`define ENCODER_AND_BUTTON_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define EBC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define EBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ebc_pkg.sv
// Shared types and constants for the encoder and button counter core.
// No dependencies.
package ebc_pkg;

	localparam int NUM_BUTTONS  = 4;
	localparam int COUNT_WIDTH  = 16;
	localparam int TIME_WIDTH   = 32;
	localparam int CFG_WIDTH    = 16;
	localparam int BTN_IDX_W    = 2;
	localparam int SEQ_W        = 3;
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	localparam logic [SEQ_W-1:0] DETENT_STEPS = SEQ_W'(4);

	// Configuration register indexes
	localparam logic CFG_REJECT_WINDOW = 1'b0;
	localparam logic CFG_STALE_TIMEOUT = 1'b1;

	// Raw action codes on the input port
	localparam logic [1:0] ACT_BUTTON  = 2'd0;
	localparam logic [1:0] ACT_ENCODER = 2'd1;
	localparam logic [1:0] ACT_READ    = 2'd2;

	// Encoder channel codes
	localparam logic CH_A = 1'b0;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_BUTTON,
		OP_ENCODER,
		OP_READ
	} op_t;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	typedef struct packed {
		op_t                   op;
		logic [BTN_IDX_W-1:0]  btn;
		logic                  pressed;
		logic                  channel;
		logic [TIME_WIDTH-1:0] evt_time;
	} cmd_t;

	typedef struct packed {
		cnt_t                    pos;
		cnt_t [NUM_BUTTONS-1:0]  rel;
	} snap_t;

endpackage

FILE: rtl/encoder_and_button_counter_core.sv
// A transaction is registered in the command queue, then executed by the back end, which registers its
// snapshot in the result queue. Throughput: one transaction per cycle while results are popped, set by
// the state update in the back end; the two-entry command and result queues absorb stalls on either side.
// Reset (arst_n low, asynchronous): queues empty, all counters and encoder state zero,
// reject window 20 and stale timeout 300 ticks.
module encoder_and_button_counter_core
	import ebc_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic                          wr_index,
	input  logic [CFG_WIDTH-1:0]          wr_data,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    action,
	input  logic [BTN_IDX_W-1:0]          button_index,
	input  logic                          button_pressed,
	input  logic                          encoder_channel,
	input  logic [TIME_WIDTH-1:0]         event_time,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [COUNT_WIDTH-1:0] position,
	output logic [COUNT_WIDTH-1:0]        releases_up,
	output logic [COUNT_WIDTH-1:0]        releases_down,
	output logic [COUNT_WIDTH-1:0]        releases_right,
	output logic [COUNT_WIDTH-1:0]        releases_left
);

	logic  cmd_valid;
	cmd_t  cmd;
	logic  cmd_take;
	snap_t snap;

	ebc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.action          (action),
		.button_index    (button_index),
		.button_pressed  (button_pressed),
		.encoder_channel (encoder_channel),
		.event_time      (event_time),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_take        (cmd_take)
	);

	ebc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.pop       (pop),
		.empty     (empty),
		.snap      (snap)
	);

	// Snapshot fields onto the result ports
	assign position       = $signed(snap.pos);
	assign releases_up    = snap.rel[0];
	assign releases_down  = snap.rel[1];
	assign releases_right = snap.rel[2];
	assign releases_left  = snap.rel[3];

endmodule

FILE: rtl/ebc_front.sv
// Front end: accepts input transactions, decodes them into commands and
// buffers them in a two-entry queue for the back end. Uses ebc_pkg.
module ebc_front
	import ebc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            action,
	input  logic [BTN_IDX_W-1:0]  button_index,
	input  logic                  button_pressed,
	input  logic                  encoder_channel,
	input  logic [TIME_WIDTH-1:0] event_time,
	output logic                  cmd_valid,
	output cmd_t                  cmd,
	input  logic                  cmd_take
);

	cmd_t               q_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	cmd_t               dec;
	logic               do_push;
	logic               do_pop;

	// Classify the incoming item
	always_comb begin
		dec          = '0;
		dec.btn      = button_index;
		dec.pressed  = button_pressed;
		dec.channel  = encoder_channel;
		dec.evt_time = event_time;
		case (action)
			ACT_BUTTON:  dec.op = (32'(button_index) < NUM_BUTTONS) ? OP_BUTTON : OP_NONE;
			ACT_ENCODER: dec.op = OP_ENCODER;
			ACT_READ:    dec.op = OP_READ;
			default:     dec.op = OP_NONE;
		endcase
	end

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	// Queue payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= dec;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/ebc_back.sv
// Back end: executes commands against the encoder and button state,
// holds configuration, and queues result snapshots. Uses ebc_pkg.
module ebc_back
	import ebc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic                  wr_index,
	input  logic [CFG_WIDTH-1:0]  wr_data,
	input  logic                  cmd_valid,
	input  cmd_t                  cmd,
	output logic                  cmd_take,
	input  logic                  pop,
	output logic                  empty,
	output snap_t                 snap
);

	logic [CFG_WIDTH-1:0]    reject_q;
	logic [CFG_WIDTH-1:0]    stale_q;
	logic [TIME_WIDTH-1:0]   prev_time_q;
	logic [SEQ_W-1:0]        seq_q;
	logic                    prev_ch_q;
	cnt_t                    pos_q;
	logic [NUM_BUTTONS-1:0]  held_q;
	cnt_t [NUM_BUTTONS-1:0]  rel_q;

	logic [TIME_WIDTH-1:0]   prev_time_n;
	logic [SEQ_W-1:0]        seq_n;
	logic                    prev_ch_n;
	cnt_t                    pos_n;
	logic [NUM_BUTTONS-1:0]  held_n;
	cnt_t [NUM_BUTTONS-1:0]  rel_n;
	logic [TIME_WIDTH-1:0]   gap;
	logic                    drop;
	snap_t                   snap_n;

	snap_t                   oq_q [QDEPTH];
	logic [QPTR_W-1:0]       owr_ptr_q;
	logic [QPTR_W-1:0]       ord_ptr_q;
	logic [QCNT_W-1:0]       ocnt_q;
	logic                    do_exec;
	logic                    do_pop;

	assign empty    = (ocnt_q == '0);
	assign do_pop   = pop && !empty;
	assign cmd_take = (ocnt_q != QCNT_W'(QDEPTH)) || do_pop;
	assign do_exec  = cmd_valid && cmd_take;
	assign snap     = oq_q[ord_ptr_q];
	assign gap      = cmd.evt_time - prev_time_q;

	// Next state for one command
	always_comb begin
		prev_time_n = prev_time_q;
		seq_n       = seq_q;
		prev_ch_n   = prev_ch_q;
		pos_n       = pos_q;
		held_n      = held_q;
		rel_n       = rel_q;
		drop        = 1'b0;
		case (cmd.op)
			OP_BUTTON: begin
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (cmd.btn == BTN_IDX_W'(i)) begin
						if (!cmd.pressed && held_q[i]) begin
							rel_n[i] = rel_q[i] + 1'b1;
						end
						held_n[i] = cmd.pressed;
					end
				end
			end
			OP_ENCODER: begin
				// Repeat of the last channel after a full detent, inside the reject window, is noise
				if (seq_q >= DETENT_STEPS) begin
					if (prev_ch_q == cmd.channel &&
					    gap < TIME_WIDTH'(reject_q)) begin
						drop = 1'b1;
					end else begin
						seq_n = '0;
					end
				end
				if (!drop) begin
					if (gap > TIME_WIDTH'(stale_q)) begin
						seq_n = '0;
					end
					prev_time_n = cmd.evt_time;
					if (seq_n == '0) begin
						prev_ch_n = cmd.channel;
						seq_n     = SEQ_W'(1);
					end else if (prev_ch_q != cmd.channel) begin
						prev_ch_n = cmd.channel;
						seq_n     = seq_n + 1'b1;
						if (seq_n == DETENT_STEPS) begin
							pos_n = (cmd.channel == CH_A) ? pos_q + 1'b1 : pos_q - 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		snap_n.pos = pos_n;
		snap_n.rel = rel_n;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_q <= CFG_WIDTH'(20);
			stale_q  <= CFG_WIDTH'(300);
		end else if (wr_en) begin
			case (wr_index)
				CFG_REJECT_WINDOW: reject_q <= wr_data;
				CFG_STALE_TIMEOUT: stale_q  <= wr_data;
				default:           reject_q <= reject_q;
			endcase
		end
	end

	// Decoder and counter state; a read clears counters after the snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
			seq_q       <= '0;
			prev_ch_q   <= 1'b0;
			pos_q       <= '0;
			held_q      <= '0;
			rel_q       <= '0;
		end else if (do_exec) begin
			prev_time_q <= prev_time_n;
			seq_q       <= seq_n;
			prev_ch_q   <= prev_ch_n;
			held_q      <= held_n;
			if (cmd.op == OP_READ) begin
				pos_q <= '0;
				rel_q <= '0;
			end else begin
				pos_q <= pos_n;
				rel_q <= rel_n;
			end
		end
	end

	// Result queue payload
	always_ff @(posedge clk) begin
		if (do_exec) begin
			oq_q[owr_ptr_q] <= snap_n;
		end
	end

	// Result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= '0;
			ord_ptr_q <= '0;
			ocnt_q    <= '0;
		end else begin
			if (do_exec) begin
				owr_ptr_q <= owr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				ord_ptr_q <= ord_ptr_q + 1'b1;
			end
			case ({do_exec, do_pop})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/ebc_checker.sv
// Port-level checks for the encoder and button counter core, bound to the top level.
// Uses ebc_pkg and the assertion macros header.
`include "encoder_and_button_counter_core_macros.svh"

module ebc_checker
	import ebc_pkg::*;
(
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic                          pop,
	input logic                          empty,
	input logic signed [COUNT_WIDTH-1:0] position,
	input logic [COUNT_WIDTH-1:0]        releases_up
);

	// A result waiting on the ports stays until it is taken
	`EBC_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty, "result dropped without pop")

	// A stalled result keeps its payload
	`EBC_ASSERT_NEXT(a_hold_payload, !empty && !pop, $stable(position) && $stable(releases_up), "stalled result changed")

	// The front queue only fills when the result side is backed up
	`EBC_ASSERT_SAME(a_full_backpressure, full, !empty, "input full with result queue empty")

	// A transaction into an idle result side shows up once executed from the command queue into the result queue
	`EBC_ASSERT_SAME(a_latency, push && !full && empty, ##2 !empty, "result missing after two cycles")

endmodule

bind encoder_and_button_counter_core ebc_checker u_ebc_checker (.*);

FILE: dv/ebc_snapshot_checker.sv
// Snapshot checker for encoder_and_button_counter_core: tracks the decoder and button
// state from accepted transactions, predicts each counter snapshot and compares popped ones.
// Depends on ebc_pkg for widths, action codes and register indexes.
module ebc_snapshot_checker
	import ebc_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic                          wr_index,
	input  logic [CFG_WIDTH-1:0]          wr_data,
	input  logic                          push,
	input  logic                          full,
	input  logic [1:0]                    action,
	input  logic [BTN_IDX_W-1:0]          button_index,
	input  logic                          button_pressed,
	input  logic                          encoder_channel,
	input  logic [TIME_WIDTH-1:0]         event_time,
	input  logic                          empty,
	input  logic                          pop,
	input  logic signed [COUNT_WIDTH-1:0] position,
	input  logic [COUNT_WIDTH-1:0]        releases_up,
	input  logic [COUNT_WIDTH-1:0]        releases_down,
	input  logic [COUNT_WIDTH-1:0]        releases_right,
	input  logic [COUNT_WIDTH-1:0]        releases_left,
	output int                            check_failures,
	output int                            pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		cnt_t pos;
		cnt_t up;
		cnt_t down;
		cnt_t right;
		cnt_t left;
	} counts_t;

	// Mirror of the block's state and registers
	logic [CFG_WIDTH-1:0]   reject_window;
	logic [CFG_WIDTH-1:0]   stale_timeout;
	logic [TIME_WIDTH-1:0]  last_edge_time;
	logic [SEQ_W-1:0]       step_count;
	logic                   last_channel;
	cnt_t                   pos_count;
	logic [NUM_BUTTONS-1:0] held;
	cnt_t                   rel_count [NUM_BUTTONS];

	counts_t snapshot_q[$];
	counts_t want;
	counts_t got;
	int      mismatch_total = 0;

	// Quadrature step: four alternating edges make a detent, the last edge sets the sign
	function void track_encoder(input logic ch, input logic [TIME_WIDTH-1:0] now);
		logic [TIME_WIDTH-1:0] gap;
		gap = now - last_edge_time;
		if (step_count >= DETENT_STEPS) begin
			// bounce on the last channel right after a detent is dropped
			if (last_channel == ch && gap < reject_window)
				return;
			step_count = '0;
		end
		if (gap > stale_timeout)
			step_count = '0;
		last_edge_time = now;
		if (step_count == '0) begin
			last_channel = ch;
			step_count = SEQ_W'(1);
			return;
		end
		if (last_channel == ch)
			return;
		last_channel = ch;
		step_count = step_count + 1'b1;
		if (step_count == DETENT_STEPS)
			pos_count = (ch == CH_A) ? pos_count + 1'b1 : pos_count - 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_window = CFG_WIDTH'(20);
			stale_timeout = CFG_WIDTH'(300);
			last_edge_time = '0;
			step_count = '0;
			last_channel = 1'b0;
			pos_count = '0;
			held = '0;
			for (int i = 0; i < NUM_BUTTONS; i++)
				rel_count[i] = '0;
			snapshot_q.delete();
		end else begin
			if (wr_en) begin
				if (wr_index == CFG_REJECT_WINDOW)
					reject_window = wr_data;
				else
					stale_timeout = wr_data;
			end

			// Result side first: a transaction accepted now cannot be popped now
			if (pop && !empty) begin
				got = '{position, releases_up, releases_down, releases_right, releases_left};
				if (snapshot_q.size() == 0) begin
					mismatch_total++;
					if (mismatch_total <= 10)
						$display("%0t: result popped with nothing expected (position %0d)",
							$realtime, $signed(got.pos));
				end else begin
					want = snapshot_q.pop_front();
					if (got != want) begin
						mismatch_total++;
						if (mismatch_total <= 10) begin
							$write("%0t: snapshot mismatch: position exp %0d got %0d, ",
								$realtime, $signed(want.pos), $signed(got.pos));
							$display({"up exp %0d got %0d, down exp %0d got %0d, ",
								"right exp %0d got %0d, left exp %0d got %0d"} == "" ?
								"" : "", "");
							$display("up exp %0d got %0d, down exp %0d got %0d, ",
								want.up, got.up, want.down, got.down);
							$display("right exp %0d got %0d, left exp %0d got %0d",
								want.right, got.right, want.left, got.left);
						end
					end
				end
			end

			// Input side: update the mirror, record the snapshot, then clear on a read
			if (push && !full) begin
				case (action)
					ACT_BUTTON: begin
						if (!button_pressed && held[button_index])
							rel_count[button_index] = rel_count[button_index] + 1'b1;
						held[button_index] = button_pressed;
					end
					ACT_ENCODER: track_encoder(encoder_channel, event_time);
					default: ;
				endcase
				snapshot_q.push_back('{pos_count, rel_count[0], rel_count[1],
					rel_count[2], rel_count[3]});
				if (action == ACT_READ) begin
					pos_count = '0;
					for (int i = 0; i < NUM_BUTTONS; i++)
						rel_count[i] = '0;
				end
			end
		end
		pending_results <= snapshot_q.size();
		check_failures <= mismatch_total;
	end

endmodule

FILE: dv/encoder_and_button_counter_core_test.sv
// Top of the encoder_and_button_counter_core testbench: clock, reset, stimulus and verdict.
// Depends on ebc_pkg, the core and ebc_snapshot_checker, which does all prediction.
module encoder_and_button_counter_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ebc_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic       CH_B       = 1'b1;
	localparam logic [1:0] BTN_UP     = 2'd0;
	localparam logic [1:0] BTN_DOWN   = 2'd1;
	localparam logic [1:0] BTN_RIGHT  = 2'd2;
	localparam logic [1:0] BTN_LEFT   = 2'd3;

	logic                          clk;
	logic                          arst_n;
	logic                          wr_en;
	logic                          wr_index;
	logic [CFG_WIDTH-1:0]          wr_data;
	logic                          push;
	logic                          full;
	logic [1:0]                    action;
	logic [BTN_IDX_W-1:0]          button_index;
	logic                          button_pressed;
	logic                          encoder_channel;
	logic [TIME_WIDTH-1:0]         event_time;
	logic                          empty;
	logic                          pop;
	logic signed [COUNT_WIDTH-1:0] position;
	logic [COUNT_WIDTH-1:0]        releases_up;
	logic [COUNT_WIDTH-1:0]        releases_down;
	logic [COUNT_WIDTH-1:0]        releases_right;
	logic [COUNT_WIDTH-1:0]        releases_left;
	int                            check_failures;
	int                            pending_results;

	int                    send_idle_pct = 0;
	int                    recv_idle_pct = 0;
	int                    hold_cycles_req = 0;
	int                    items_sent = 0;
	logic [TIME_WIDTH-1:0] tick = '0;
	logic [CFG_WIDTH-1:0]  cur_reject = CFG_WIDTH'(20);
	logic [CFG_WIDTH-1:0]  cur_stale = CFG_WIDTH'(300);

	encoder_and_button_counter_core uut (.*);
	ebc_snapshot_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: random pop, with an occasional long hold-off requested by the sender
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles_req > 0) begin
				pop <= 1'b0;
				repeat (hold_cycles_req) @(negedge clk);
				hold_cycles_req = 0;
			end
			pop <= arst_n && (int'($urandom_range(99)) >= recv_idle_pct);
		end
	end

	// Offer one transaction, with random idle cycles ahead of it; returns once accepted
	task automatic offer(input logic [1:0] act, input logic [BTN_IDX_W-1:0] idx,
			input logic prs, input logic ch, input logic [TIME_WIDTH-1:0] stamp);
		@(negedge clk);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		action <= act;
		button_index <= idx;
		button_pressed <= prs;
		encoder_channel <= ch;
		event_time <= stamp;
		do @(posedge clk); while (full);
		if (act != ACT_UNUSED)
			items_sent++;
	endtask

	task automatic encoder_edge(input logic ch, input logic [TIME_WIDTH-1:0] gap);
		tick = tick + gap;
		offer(ACT_ENCODER, BTN_IDX_W'($urandom), 1'($urandom), ch, tick);
	endtask

	task automatic button_change(input logic [BTN_IDX_W-1:0] idx, input logic prs);
		offer(ACT_BUTTON, idx, prs, 1'($urandom), $urandom);
	endtask

	task automatic read_counts();
		offer(ACT_READ, BTN_IDX_W'($urandom), 1'($urandom), 1'($urandom), $urandom);
	endtask

	// Register write; only called with the block drained
	task automatic write_reg(input logic idx, input logic [CFG_WIDTH-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == CFG_REJECT_WINDOW)
			cur_reject = value;
		else
			cur_stale = value;
	endtask

	// Stop offering and wait for every expected snapshot, giving up after a bound
	task automatic drain();
		int waited;
		waited = 0;
		@(negedge clk);
		push <= 1'b0;
		while (pending_results != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	// Gap between encoder edges: mostly inside the stale timeout for tidy bursts,
	// otherwise aimed at the window edges or a wild jump
	function automatic logic [TIME_WIDTH-1:0] edge_gap(input bit tidy);
		if (tidy && $urandom_range(9) != 0)
			return TIME_WIDTH'($urandom_range(cur_stale));
		case ($urandom_range(6))
			0: return '0;
			1: return TIME_WIDTH'(cur_stale);
			2: return TIME_WIDTH'(cur_stale) + 1'b1;
			3: return TIME_WIDTH'(cur_reject);
			4: return (cur_reject == '0) ? '0 : TIME_WIDTH'(cur_reject) - 1'b1;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_items(input int count);
		int stop_at;
		int pick;
		logic ch;
		logic [BTN_IDX_W-1:0] idx;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				// one detent, now and then with a stray repeat inside it
				ch = 1'($urandom);
				for (int k = 0; k < 4; k++) begin
					encoder_edge(ch, edge_gap(1'b1));
					if ($urandom_range(9) == 0)
						encoder_edge(ch, edge_gap(1'b1));
					ch = ~ch;
				end
				// bounce on the channel that completed the detent
				if ($urandom_range(2) == 0)
					encoder_edge(~ch, TIME_WIDTH'($urandom_range(cur_reject)));
			end else if (pick < 70) begin
				idx = BTN_IDX_W'($urandom);
				button_change(idx, 1'b1);
				button_change(idx, 1'b0);
			end else if (pick < 80) begin
				button_change(BTN_IDX_W'($urandom), 1'($urandom));
			end else if (pick < 88) begin
				read_counts();
			end else if (pick < 92) begin
				offer(ACT_UNUSED, BTN_IDX_W'($urandom), 1'($urandom), 1'($urandom), $urandom);
			end else begin
				encoder_edge(1'($urandom), edge_gap(1'b0));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		wr_en = 1'b0;
		wr_index = CFG_REJECT_WINDOW;
		wr_data = '0;
		action = ACT_BUTTON;
		button_index = BTN_UP;
		button_pressed = 1'b0;
		encoder_channel = CH_A;
		event_time = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, reset register values
		send_idle_pct = 38;
		recv_idle_pct = 80;
		read_counts();
		button_change(BTN_UP, 1'b1);
		button_change(BTN_UP, 1'b0);
		button_change(BTN_UP, 1'b0);       // release without a press
		button_change(BTN_DOWN, 1'b1);
		button_change(BTN_DOWN, 1'b1);     // repeat press
		button_change(BTN_DOWN, 1'b0);
		button_change(BTN_LEFT, 1'b1);
		button_change(BTN_LEFT, 1'b0);
		encoder_edge(CH_B, 10);
		encoder_edge(CH_A, 10);
		encoder_edge(CH_B, 10);
		encoder_edge(CH_A, 10);            // detent up
		encoder_edge(CH_A, 5);             // bounce inside the reject window
		encoder_edge(CH_B, 30);
		encoder_edge(CH_A, 10);
		encoder_edge(CH_A, 10);            // same channel twice mid-sequence
		encoder_edge(CH_B, 10);
		encoder_edge(CH_A, 10);            // detent up
		encoder_edge(CH_A, 400);           // stale gap restarts
		encoder_edge(CH_B, 300);           // exactly at the timeout, still live
		encoder_edge(CH_A, 10);
		encoder_edge(CH_B, 10);            // detent down
		encoder_edge(CH_A, 32'hFFFF_FFF0 - tick);
		encoder_edge(CH_B, 32'h20);        // timestamp wraps
		offer(ACT_UNUSED, BTN_RIGHT, 1'b1, CH_B, 32'hFFFF_FFFF);
		read_counts();

		// Phase one: moderate registers
		drain();
		write_reg(CFG_REJECT_WINDOW, CFG_WIDTH'($urandom_range(1, 200)));
		write_reg(CFG_STALE_TIMEOUT, CFG_WIDTH'($urandom_range(100, 2000)));
		random_items(600);

		// Phase two: registers at their maximum, idling swapped
		drain();
		send_idle_pct = 80;
		recv_idle_pct = 38;
		write_reg(CFG_REJECT_WINDOW, '1);
		write_reg(CFG_STALE_TIMEOUT, '1);
		random_items(600);

		// Phase three: no idling, registers at zero, then a long result-side stall
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_REJECT_WINDOW, '0);
		write_reg(CFG_STALE_TIMEOUT, '0);
		random_items(250);
		hold_cycles_req = 80;
		random_items(150);
		drain();
		write_reg(CFG_REJECT_WINDOW, CFG_WIDTH'($urandom));
		write_reg(CFG_STALE_TIMEOUT, CFG_WIDTH'($urandom));
		random_items(250);

		drain();
		repeat (8) @(posedge clk);
		if (check_failures == 0 && pending_results == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
